@@ rtl/assert_macros.svh @@
// Assertion macros shared by the Salsa20 keystream RTL.
// No dependencies; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define S20_ASSERT(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define S20_NEVER(label, clk_sig, rst_n_sig, expr, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) !(expr)) else $error(msg);

`endif

@@ rtl/s20_pkg.sv @@
// Shared types, constants and round functions of the Salsa20 keystream block.
// No dependencies; used by every module of the block but s20_front.
package s20_pkg;

	localparam int WORDS = 16;

	typedef logic [31:0] word_t;
	typedef logic [15:0][31:0] state_t;
	typedef logic [3:0][31:0] quad_t;
	typedef logic [3:0] widx_t;

	localparam widx_t LAST_WORD_IDX = 4'd15;

	// "expand 32-byte k" constant words.
	localparam word_t SIGMA_0 = 32'h6170_7865;
	localparam word_t SIGMA_1 = 32'h3320_646e;
	localparam word_t SIGMA_2 = 32'h7962_2d32;
	localparam word_t SIGMA_3 = 32'h6b20_6574;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_KEY_01 = 3'd0,
		REG_KEY_23 = 3'd1,
		REG_KEY_45 = 3'd2,
		REG_KEY_67 = 3'd3,
		REG_NONCE  = 3'd4
	} reg_idx_t;

	// Key and nonce as held by the configuration registers.
	typedef struct packed {
		logic [63:0] key_01;
		logic [63:0] key_23;
		logic [63:0] key_45;
		logic [63:0] key_67;
		logic [63:0] nonce;
	} cfg_t;

	// Round engine states.
	typedef enum logic [1:0] {
		CORE_IDLE,
		CORE_ROUND,
		CORE_DONE
	} core_state_t;

	function automatic word_t rotl(input word_t v, input int n);
		rotl = (v << n) | (v >> (32 - n));
	endfunction

	// One quarter-round; element 0..3 of the result are the new a, b, c, d.
	function automatic quad_t quarter(input word_t a, input word_t b,
			input word_t c, input word_t d);
		word_t a1, b1, c1, d1, t;
		quad_t q;
		t = a + d;
		b1 = b ^ rotl(t, 7);
		t = b1 + a;
		c1 = c ^ rotl(t, 9);
		t = c1 + b1;
		d1 = d ^ rotl(t, 13);
		t = d1 + c1;
		a1 = a ^ rotl(t, 18);
		q[0] = a1;
		q[1] = b1;
		q[2] = c1;
		q[3] = d1;
		return q;
	endfunction

	function automatic state_t column_round(input state_t s);
		state_t r;
		quad_t q;
		r = s;
		q = quarter(s[0], s[4], s[8], s[12]);
		r[0] = q[0]; r[4] = q[1]; r[8] = q[2]; r[12] = q[3];
		q = quarter(s[5], s[9], s[13], s[1]);
		r[5] = q[0]; r[9] = q[1]; r[13] = q[2]; r[1] = q[3];
		q = quarter(s[10], s[14], s[2], s[6]);
		r[10] = q[0]; r[14] = q[1]; r[2] = q[2]; r[6] = q[3];
		q = quarter(s[15], s[3], s[7], s[11]);
		r[15] = q[0]; r[3] = q[1]; r[7] = q[2]; r[11] = q[3];
		return r;
	endfunction

	function automatic state_t row_round(input state_t s);
		state_t r;
		quad_t q;
		r = s;
		q = quarter(s[0], s[1], s[2], s[3]);
		r[0] = q[0]; r[1] = q[1]; r[2] = q[2]; r[3] = q[3];
		q = quarter(s[5], s[6], s[7], s[4]);
		r[5] = q[0]; r[6] = q[1]; r[7] = q[2]; r[4] = q[3];
		q = quarter(s[10], s[11], s[8], s[9]);
		r[10] = q[0]; r[11] = q[1]; r[8] = q[2]; r[9] = q[3];
		q = quarter(s[15], s[12], s[13], s[14]);
		r[15] = q[0]; r[12] = q[1]; r[13] = q[2]; r[14] = q[3];
		return r;
	endfunction

	// Starting state from constants, key, nonce and block position.
	function automatic state_t build_state(input cfg_t cfg, input logic [63:0] pos);
		state_t s;
		s[0]  = SIGMA_0;
		s[1]  = cfg.key_01[31:0];
		s[2]  = cfg.key_01[63:32];
		s[3]  = cfg.key_23[31:0];
		s[4]  = cfg.key_23[63:32];
		s[5]  = SIGMA_1;
		s[6]  = cfg.nonce[31:0];
		s[7]  = cfg.nonce[63:32];
		s[8]  = pos[31:0];
		s[9]  = pos[63:32];
		s[10] = SIGMA_2;
		s[11] = cfg.key_45[31:0];
		s[12] = cfg.key_45[63:32];
		s[13] = cfg.key_67[31:0];
		s[14] = cfg.key_67[63:32];
		s[15] = SIGMA_3;
		return s;
	endfunction

endpackage

@@ rtl/s20_front.sv @@
// Input side of the Salsa20 keystream block: a two-entry queue of block positions.
// Depends on nothing but the clock and reset; feeds s20_core.
module s20_front (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [63:0] block_position,
	output logic        pos_valid,
	input  logic        pos_ready,
	output logic [63:0] pos_data
);

	logic [63:0] mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        do_push;
	logic        do_pop;

	assign full      = (count_q == 2'd2);
	assign pos_valid = (count_q != 2'd0);
	assign pos_data  = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pos_valid && pos_ready;

	// Queue storage; written on each accepted transfer.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= block_position;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

@@ rtl/s20_core.sv @@
// Salsa20 round engine: loads a starting state, runs one round of four quarter-rounds
// per cycle and hands the finished block on. Depends on s20_pkg and assert_macros.svh.
`include "assert_macros.svh"

module s20_core #(
	parameter int ROUND_COUNT = 20
) (
	input  logic            clk,
	input  logic            arst_n,
	input  s20_pkg::cfg_t   cfg,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [63:0]     in_pos,
	output logic            out_valid,
	input  logic            out_ready,
	output s20_pkg::state_t out_block
);

	localparam int RW = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
	localparam logic [RW-1:0] LAST_ROUND = RW'(ROUND_COUNT - 1);

	s20_pkg::core_state_t state_q;
	s20_pkg::core_state_t state_d;
	s20_pkg::state_t      work_q;
	s20_pkg::state_t      start_q;
	logic [RW-1:0]        round_q;
	logic                 load;
	logic                 last_round;

	assign last_round = (round_q == LAST_ROUND);
	assign load       = in_valid && in_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			s20_pkg::CORE_IDLE: begin
				if (in_valid) begin
					state_d = s20_pkg::CORE_ROUND;
				end
			end
			s20_pkg::CORE_ROUND: begin
				if (last_round) begin
					state_d = s20_pkg::CORE_DONE;
				end
			end
			s20_pkg::CORE_DONE: begin
				if (out_ready) begin
					state_d = in_valid ? s20_pkg::CORE_ROUND : s20_pkg::CORE_IDLE;
				end
			end
			default: state_d = s20_pkg::CORE_IDLE;
		endcase
	end

	// Handshake outputs; a new block loads in the same cycle the old one is handed off.
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			s20_pkg::CORE_IDLE:  in_ready = 1'b1;
			s20_pkg::CORE_ROUND: in_ready = 1'b0;
			s20_pkg::CORE_DONE: begin
				out_valid = 1'b1;
				in_ready  = out_ready;
			end
			default: in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= s20_pkg::CORE_IDLE;
			round_q <= '0;
		end else begin
			state_q <= state_d;
			if (load) begin
				round_q <= '0;
			end else if (state_q == s20_pkg::CORE_ROUND) begin
				round_q <= round_q + RW'(1);
			end
		end
	end

	// Working state: even rounds work on columns, odd rounds on rows.
	always_ff @(posedge clk) begin
		if (load) begin
			work_q  <= s20_pkg::build_state(cfg, in_pos);
			start_q <= s20_pkg::build_state(cfg, in_pos);
		end else if (state_q == s20_pkg::CORE_ROUND) begin
			work_q <= round_q[0] ? s20_pkg::row_round(work_q)
			                     : s20_pkg::column_round(work_q);
		end
	end

	// Feed-forward of the starting state, word by word modulo 2^32.
	always_comb begin
		for (int i = 0; i < s20_pkg::WORDS; i++) begin
			out_block[i] = work_q[i] + start_q[i];
		end
	end

	`S20_ASSERT(a_round_bound, clk, arst_n, state_q == s20_pkg::CORE_ROUND |-> round_q <= LAST_ROUND, "round counter ran past the last round")
	`S20_ASSERT(a_last_to_done, clk, arst_n, state_q == s20_pkg::CORE_ROUND && last_round |=> state_q == s20_pkg::CORE_DONE, "last round did not finish the block")
	`S20_ASSERT(a_done_holds, clk, arst_n, state_q == s20_pkg::CORE_DONE && !out_ready |=> state_q == s20_pkg::CORE_DONE && $stable(work_q), "finished block changed before handoff")

endmodule

@@ rtl/s20_drain.sv @@
// Output side of the Salsa20 keystream block: holds one finished block and
// offers its words in order. Depends on s20_pkg and assert_macros.svh.
`include "assert_macros.svh"

module s20_drain (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            blk_valid,
	output logic            blk_ready,
	input  s20_pkg::state_t blk_data,
	output logic            empty,
	input  logic            pop,
	output logic [3:0]      word_index,
	output logic [31:0]     keystream_word,
	output logic            last_word
);

	s20_pkg::word_t  buf_q [s20_pkg::WORDS];
	s20_pkg::widx_t  idx_q;
	logic            valid_q;
	logic            at_last;
	logic            do_pop;
	logic            do_load;

	assign at_last        = (idx_q == s20_pkg::LAST_WORD_IDX);
	assign do_pop         = pop && valid_q;
	assign blk_ready      = !valid_q || (do_pop && at_last);
	assign do_load        = blk_valid && blk_ready;
	assign empty          = !valid_q;
	assign word_index     = idx_q;
	assign keystream_word = buf_q[idx_q];
	assign last_word      = at_last;

	// Block buffer, loaded whole from the round engine.
	always_ff @(posedge clk) begin
		if (do_load) begin
			for (int i = 0; i < s20_pkg::WORDS; i++) begin
				buf_q[i] <= blk_data[i];
			end
		end
	end

	// Word pointer and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (do_load) begin
				idx_q   <= '0;
				valid_q <= 1'b1;
			end else if (do_pop) begin
				idx_q <= idx_q + 4'd1;
				if (at_last) begin
					valid_q <= 1'b0;
				end
			end
		end
	end

	`S20_ASSERT(a_hold_word, clk, arst_n, valid_q && !pop |=> valid_q && $stable(idx_q), "waiting word moved without a transfer")
	`S20_NEVER(a_load_mid_block, clk, arst_n, do_load && valid_q && !at_last, "new block overwrote an unfinished one")

endmodule

@@ rtl/salsa20_block_function_top.sv @@
// Salsa20 keystream block generator: one 64-bit block position in, sixteen
// 32-bit keystream words out in order, the sixteenth flagged as last. Key and
// nonce are written over the APB port (64-bit registers at byte addresses 0x00,
// 0x08, 0x10, 0x18 for key word pairs 0/1 through 6/7 and 0x20 for the nonce,
// low word in bits 31:0). Write them only while the block is idle; the block
// itself does not enforce this. The round engine runs one round per cycle, and
// a block's 16 words drain at one per cycle while pop is held, as the next
// block computes.
// Depends on s20_pkg, s20_front, s20_core and s20_drain.
module salsa20_block_function_top #(
	parameter int ROUND_COUNT = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	// Input queue side
	input  logic        push,
	output logic        full,
	input  logic [63:0] block_position,
	// Result queue side
	output logic        empty,
	input  logic        pop,
	output logic [3:0]  word_index,
	output logic [31:0] keystream_word,
	output logic        last_word
);

	s20_pkg::cfg_t   cfg_q;
	logic [2:0]      reg_sel;
	logic            cfg_wr;
	logic            pos_valid;
	logic            pos_ready;
	logic [63:0]     pos_data;
	logic            blk_valid;
	logic            blk_ready;
	s20_pkg::state_t blk_data;

	assign pready  = 1'b1;
	assign reg_sel = paddr[5:3];
	assign cfg_wr  = psel && penable && pwrite && pready;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				s20_pkg::REG_KEY_01: cfg_q.key_01 <= pwdata;
				s20_pkg::REG_KEY_23: cfg_q.key_23 <= pwdata;
				s20_pkg::REG_KEY_45: cfg_q.key_45 <= pwdata;
				s20_pkg::REG_KEY_67: cfg_q.key_67 <= pwdata;
				s20_pkg::REG_NONCE:  cfg_q.nonce  <= pwdata;
				default: ;
			endcase
		end
	end

	// Configuration register reads.
	always_comb begin
		unique case (reg_sel)
			s20_pkg::REG_KEY_01: prdata = cfg_q.key_01;
			s20_pkg::REG_KEY_23: prdata = cfg_q.key_23;
			s20_pkg::REG_KEY_45: prdata = cfg_q.key_45;
			s20_pkg::REG_KEY_67: prdata = cfg_q.key_67;
			s20_pkg::REG_NONCE:  prdata = cfg_q.nonce;
			default:             prdata = '0;
		endcase
	end

	s20_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.block_position (block_position),
		.pos_valid      (pos_valid),
		.pos_ready      (pos_ready),
		.pos_data       (pos_data)
	);

	s20_core #(
		.ROUND_COUNT (ROUND_COUNT)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (pos_valid),
		.in_ready  (pos_ready),
		.in_pos    (pos_data),
		.out_valid (blk_valid),
		.out_ready (blk_ready),
		.out_block (blk_data)
	);

	s20_drain u_drain (
		.clk            (clk),
		.arst_n         (arst_n),
		.blk_valid      (blk_valid),
		.blk_ready      (blk_ready),
		.blk_data       (blk_data),
		.empty          (empty),
		.pop            (pop),
		.word_index     (word_index),
		.keystream_word (keystream_word),
		.last_word      (last_word)
	);

endmodule

@@ verif/salsa20_keystream_checker.sv @@
// Keystream checker for the Salsa20 block generator: follows the APB register
// transfers, predicts the sixteen words of every accepted block position and
// compares them with the result queue. Depends on s20_pkg.
module salsa20_keystream_checker #(
	parameter int ROUND_COUNT = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	input  logic [63:0] prdata,
	input  logic        pready,
	input  logic        push,
	input  logic        full,
	input  logic [63:0] block_position,
	input  logic        empty,
	input  logic        pop,
	input  logic [3:0]  word_index,
	input  logic [31:0] keystream_word,
	input  logic        last_word,
	output int          mismatch_count,
	output int          words_pending
);
	import s20_pkg::*;

	localparam int REG_COUNT = int'(REG_NONCE) + 1;

	// One expected word of the result queue.
	typedef struct packed {
		widx_t index;
		word_t word;
		logic  last;
	} ks_word_t;

	ks_word_t    expected_words[$];
	logic [63:0] cfg_regs [REG_COUNT];
	int          errors = 0;
	int          words_checked;

	assign mismatch_count = errors;

	task automatic report_mismatch(string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic word_t rol32(word_t v, int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	// Quarter-round on words a, b, c and d of the working state.
	function automatic state_t mix_quarter(state_t s, int a, int b, int c, int d);
		s[b] = s[b] ^ rol32(s[a] + s[d], 7);
		s[c] = s[c] ^ rol32(s[b] + s[a], 9);
		s[d] = s[d] ^ rol32(s[c] + s[b], 13);
		s[a] = s[a] ^ rol32(s[d] + s[c], 18);
		return s;
	endfunction

	// Full keystream block for one position under the current key and nonce.
	function automatic state_t keystream_block(logic [63:0] pos);
		state_t init;
		state_t w;
		init[0]  = SIGMA_0;
		init[1]  = cfg_regs[REG_KEY_01][31:0];
		init[2]  = cfg_regs[REG_KEY_01][63:32];
		init[3]  = cfg_regs[REG_KEY_23][31:0];
		init[4]  = cfg_regs[REG_KEY_23][63:32];
		init[5]  = SIGMA_1;
		init[6]  = cfg_regs[REG_NONCE][31:0];
		init[7]  = cfg_regs[REG_NONCE][63:32];
		init[8]  = pos[31:0];
		init[9]  = pos[63:32];
		init[10] = SIGMA_2;
		init[11] = cfg_regs[REG_KEY_45][31:0];
		init[12] = cfg_regs[REG_KEY_45][63:32];
		init[13] = cfg_regs[REG_KEY_67][31:0];
		init[14] = cfg_regs[REG_KEY_67][63:32];
		init[15] = SIGMA_3;
		w = init;
		// Even rounds mix columns and odd rounds mix rows, so an odd count
		// ends on a column round.
		for (int r = 0; r < ROUND_COUNT; r++) begin
			if (r % 2 == 0) begin
				w = mix_quarter(w, 0, 4, 8, 12);
				w = mix_quarter(w, 5, 9, 13, 1);
				w = mix_quarter(w, 10, 14, 2, 6);
				w = mix_quarter(w, 15, 3, 7, 11);
			end else begin
				w = mix_quarter(w, 0, 1, 2, 3);
				w = mix_quarter(w, 5, 6, 7, 4);
				w = mix_quarter(w, 10, 11, 8, 9);
				w = mix_quarter(w, 15, 12, 13, 14);
			end
		end
		for (int k = 0; k < WORDS; k++) begin
			w[k] = w[k] + init[k];
		end
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		logic [2:0] sel;
		ks_word_t   want;
		state_t     ks;
		if (!arst_n) begin
			foreach (cfg_regs[i]) cfg_regs[i] = '0;
			expected_words.delete();
			words_checked = 0;
			words_pending <= 0;
		end else begin
			sel = paddr[5:3];

			// Register transfers: writes update the local copy, reads are checked
			// against it. Addresses past the last register are ignored.
			if (psel && penable && pready && sel <= REG_NONCE) begin
				if (pwrite) begin
					cfg_regs[sel] = pwdata;
				end else if (prdata !== cfg_regs[sel]) begin
					report_mismatch($sformatf("register %0d reads %0h, expected %0h",
						sel, prdata, cfg_regs[sel]));
				end
			end

			// Result transfer: compare with the oldest expected word.
			if (pop && !empty) begin
				if (expected_words.size() == 0) begin
					report_mismatch($sformatf("word %0d (%0h) arrived with none expected",
						word_index, keystream_word));
				end else begin
					want = expected_words.pop_front();
					if (word_index !== want.index)
						report_mismatch($sformatf("block %0d word %0d: word_index %0d, expected %0d",
							words_checked / WORDS, want.index, word_index, want.index));
					if (keystream_word !== want.word)
						report_mismatch($sformatf("block %0d word %0d: keystream_word %h, expected %h",
							words_checked / WORDS, want.index, keystream_word, want.word));
					if (last_word !== want.last)
						report_mismatch($sformatf("block %0d word %0d: last_word %b, expected %b",
							words_checked / WORDS, want.index, last_word, want.last));
				end
				words_checked++;
			end

			// Input transfer: queue the sixteen words of the new block.
			if (push && !full) begin
				ks = keystream_block(block_position);
				for (int k = 0; k < WORDS; k++) begin
					want.index = widx_t'(k);
					want.word  = ks[k];
					want.last  = (widx_t'(k) == LAST_WORD_IDX);
					expected_words.push_back(want);
				end
			end

			words_pending <= expected_words.size();
		end
	end

endmodule

@@ verif/salsa20_block_function_top_test.sv @@
// Testbench top for the Salsa20 block generator: clock, reset, APB register
// setup, block position stimulus and pop control under several idle patterns.
// Depends on s20_pkg, salsa20_block_function_top and salsa20_keystream_checker.
module salsa20_block_function_top_test;
	import s20_pkg::*;

	localparam int ROUND_COUNT   = 20;
	localparam int REG_COUNT     = int'(REG_NONCE) + 1;
	localparam int STALL_LIMIT   = 4000;
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_BLOCKS = 110;
	localparam int BACKLOG_BLOCKS = 24;
	// Register slots past the nonce that hold nothing.
	localparam logic [2:0] SPARE_IDX_LO = 3'd5;
	localparam logic [2:0] SPARE_IDX_HI = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [5:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;
	logic        push;
	logic        full;
	logic [63:0] block_position;
	logic        empty;
	logic        pop;
	logic [3:0]  word_index;
	logic [31:0] keystream_word;
	logic        last_word;

	int          mismatch_count;
	int          words_pending;
	int          send_idle_pct;
	int          pop_stall_pct;
	int          hold_request;
	int          quiet_cycles = 0;
	logic [63:0] edge_positions [8];

	salsa20_block_function_top #(
		.ROUND_COUNT(ROUND_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.push(push),
		.full(full),
		.block_position(block_position),
		.empty(empty),
		.pop(pop),
		.word_index(word_index),
		.keystream_word(keystream_word),
		.last_word(last_word)
	);

	salsa20_keystream_checker #(
		.ROUND_COUNT(ROUND_COUNT)
	) ks_check (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.push(push),
		.full(full),
		.block_position(block_position),
		.empty(empty),
		.pop(pop),
		.word_index(word_index),
		.keystream_word(keystream_word),
		.last_word(last_word),
		.mismatch_count(mismatch_count),
		.words_pending(words_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side: random pop stalls, and long hold-offs on request.
	always @(negedge clk) begin : result_side
		int hold_left;
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (!arst_n || hold_left > 0) begin
			pop <= 1'b0;
			if (hold_left > 0)
				hold_left--;
		end else begin
			pop <= ($urandom_range(99) >= pop_stall_pct);
		end
	end

	// Watchdog: too long without any transfer ends the run.
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("No transfer for %0d cycles, giving up", quiet_cycles);
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Setup and access phases of one register transfer; psel stays high after.
	task automatic reg_access(logic [2:0] idx, logic is_write, logic [63:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= is_write;
		paddr   <= {idx, 3'b000};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
	endtask

	task automatic reg_release();
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Writes key and nonce, pokes an unused slot, then reads key and nonce back.
	task automatic load_config(logic [63:0] k01, logic [63:0] k23, logic [63:0] k45,
			logic [63:0] k67, logic [63:0] nonce);
		logic [63:0] vals [REG_COUNT];
		vals = '{k01, k23, k45, k67, nonce};
		for (int i = REG_KEY_01; i <= REG_NONCE; i++)
			reg_access(i[2:0], 1'b1, vals[i]);
		reg_access(3'($urandom_range(SPARE_IDX_HI, SPARE_IDX_LO)), 1'b1,
			{$urandom, $urandom});
		for (int i = REG_KEY_01; i <= REG_NONCE; i++)
			reg_access(i[2:0], 1'b0, '0);
		reg_release();
	endtask

	// Offers one block position, with random idle cycles ahead of it.
	task automatic send_block(logic [63:0] pos);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		block_position <= pos;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	// Stops offering and waits for every outstanding word.
	task automatic drain_results();
		@(negedge clk);
		push <= 1'b0;
		while (words_pending != 0) @(negedge clk);
	endtask

	// Mix of plain counters, fully random values and values near the low-half wrap.
	function automatic logic [63:0] pick_position(int count);
		case ($urandom_range(3))
			0: return 64'(count);
			1: return {$urandom, 32'hFFFF_FFF0 | 32'($urandom_range(15))};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic run_phase(int idle_pct, int stall_pct, int blocks);
		send_idle_pct = idle_pct;
		pop_stall_pct = stall_pct;
		load_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, {$urandom, $urandom});
		for (int i = 0; i < blocks; i++)
			send_block(pick_position(i));
		drain_results();
	endtask

	initial begin
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		push           = 1'b0;
		block_position = '0;
		pop            = 1'b0;
		send_idle_pct  = 0;
		pop_stall_pct  = 0;
		hold_request   = 0;
		edge_positions = '{64'h0, '1, 64'h1, 64'h0000_0000_FFFF_FFFF,
			64'hFFFF_FFFF_0000_0000, 64'hAAAA_AAAA_AAAA_AAAA,
			64'h5555_5555_5555_5555, 64'h8000_0000_8000_0000};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset values read back, then edge positions under the all-zero key.
		for (int i = REG_KEY_01; i <= REG_NONCE; i++)
			reg_access(i[2:0], 1'b0, '0);
		reg_release();
		foreach (edge_positions[i]) send_block(edge_positions[i]);
		drain_results();

		// All-ones key and nonce.
		load_config('1, '1, '1, '1, '1);
		foreach (edge_positions[i]) send_block(edge_positions[i]);
		drain_results();

		// Alternating bit patterns across key and nonce.
		load_config(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
			64'hAAAA_AAAA_5555_5555, 64'h5555_5555_AAAA_AAAA, 64'hFFFF_FFFF_0000_0000);
		for (int i = 0; i < 4; i++) send_block(edge_positions[i]);
		drain_results();

		// Random positions under random keys, one idle pattern per phase.
		run_phase(0, 0, RANDOM_BLOCKS);
		run_phase(62, 0, RANDOM_BLOCKS);
		run_phase(0, 62, RANDOM_BLOCKS);
		run_phase(33, 33, RANDOM_BLOCKS);

		// Backlog: the result side holds off while positions keep coming.
		send_idle_pct = 0;
		pop_stall_pct = 0;
		load_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, {$urandom, $urandom});
		@(posedge clk);
		hold_request = HOLD_CYCLES;
		for (int i = 0; i < BACKLOG_BLOCKS; i++)
			send_block(pick_position(i));
		drain_results();

		// Give any stray word time to show up before the verdict.
		repeat (ROUND_COUNT + 8) @(negedge clk);
		if (words_pending != 0)
			$display("%0d keystream words never arrived", words_pending);
		if (mismatch_count == 0 && words_pending == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/s20_pkg.sv
rtl/s20_front.sv
rtl/s20_core.sv
rtl/s20_drain.sv
rtl/salsa20_block_function_top.sv
verif/salsa20_keystream_checker.sv
verif/salsa20_block_function_top_test.sv
